// ===== rtl/bounded_deque_min_max_count_unit_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef BOUNDED_DEQUE_MIN_MAX_COUNT_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_MIN_MAX_COUNT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_EXT_BACK  = 3'd1;
  localparam logic [2:0] REQ_EXT_FRONT = 3'd2;
  localparam logic [2:0] REQ_MIN       = 3'd3;
  localparam logic [2:0] REQ_MAX       = 3'd4;

  typedef enum logic [1:0] {
    OP_MIN,
    OP_MAX,
    OP_COUNT
  } scan_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/bounded_deque_min_max_count_unit.sv =====
// Bounded deque of signed 32-bit values with min, max and count queries.
// Command channel: an item (req_type, count_req, value_in) is taken at a
// rising edge where start is high and busy is low. count_req overrides
// req_type and asks how many stored entries equal value_in.
// Result channel: done pulses for one cycle with ok, data_out, match_count
// and occupancy valid in that cycle. Exactly one result per item. The
// receiver has no way to stall; it must capture the result on done.
// Insert, any failed request and a count on an empty store answer straight
// from the accept; extract back / front first goes through one memory read
// (ST_WAIT); min, max and count read every stored entry in turn (ST_SCAN).
// The scans are bounded by the single read port of the entry memory: one
// entry is read per cycle. busy drops in the cycle done is shown, so the
// next item can be accepted while the result is on the ports.
// Reset (rst, synchronous) empties the deque and clears done; memory
// contents are not cleared since only written entries are ever read.
`include "bounded_deque_min_max_count_unit_macros.svh"

module bounded_deque_min_max_count_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    req_type,
  input  logic                          count_req,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_in,
  output logic                          done,
  output logic                          ok,
  output logic signed [bdq_pkg::DATA_W-1:0] data_out,
  output logic [bdq_pkg::CNT_W-1:0]     match_count,
  output logic [bdq_pkg::CNT_W-1:0]     occupancy
);
  import bdq_pkg::*;

  // entry memory: one write port, one registered read port
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic [ADDR_W-1:0]        mem_waddr;
  logic                     mem_we;

  // control state
  state_t               state, state_next;
  logic [ADDR_W-1:0]    front, front_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     issue_idx, issue_idx_next;  // next entry to read
  logic [CNT_W-1:0]     proc_idx, proc_idx_next;    // next entry to fold in
  logic                 rd_pend, rd_pend_next;      // read data valid this cycle
  logic                 done_next;

  // scan datapath / latched request
  scan_op_t                 op, op_next;
  logic signed [DATA_W-1:0] val_q, val_q_next;
  logic signed [DATA_W-1:0] best, best_next;
  logic [CNT_W-1:0]         match_acc, match_acc_next;

  // result registers
  logic                     ok_next;
  logic signed [DATA_W-1:0] data_out_next;
  logic [CNT_W-1:0]         match_count_next;
  logic [CNT_W-1:0]         occupancy_next;

  // ring position (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [ADDR_W-1:0] ring(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= val_q_next;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      front     <= '0;
      count     <= '0;
      issue_idx <= '0;
      proc_idx  <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
      op        <= OP_MIN;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      issue_idx <= issue_idx_next;
      proc_idx  <= proc_idx_next;
      rd_pend   <= rd_pend_next;
      done      <= done_next;
      op        <= op_next;
    end
  end

  always_ff @(posedge clk) begin
    val_q       <= val_q_next;
    best        <= best_next;
    match_acc   <= match_acc_next;
    ok          <= ok_next;
    data_out    <= data_out_next;
    match_count <= match_count_next;
    occupancy   <= occupancy_next;
  end

  always_comb begin
    logic                     first;
    logic signed [DATA_W-1:0] best_fold;
    logic [CNT_W-1:0]         match_fold;

    state_next       = state;
    front_next       = front;
    count_next       = count;
    issue_idx_next   = issue_idx;
    proc_idx_next    = proc_idx;
    rd_pend_next     = 1'b0;
    op_next          = op;
    val_q_next       = val_q;
    best_next        = best;
    match_acc_next   = match_acc;
    done_next        = 1'b0;
    ok_next          = ok;
    data_out_next    = data_out;
    match_count_next = match_count;
    occupancy_next   = occupancy;
    mem_we           = 1'b0;
    mem_waddr        = ring(front, count[ADDR_W-1:0]);
    mem_raddr        = front;
    first            = (proc_idx == '0);
    best_fold        = best;
    match_fold       = match_acc;

    case (state)
      ST_IDLE: begin
        if (start) begin
          val_q_next       = value_in;
          issue_idx_next   = '0;
          proc_idx_next    = '0;
          match_acc_next   = '0;
          // default: fail at once with state unchanged
          done_next        = 1'b1;
          ok_next          = 1'b0;
          data_out_next    = '0;
          match_count_next = '0;
          occupancy_next   = count;
          if (count_req) begin
            if (count == '0) begin
              ok_next = 1'b1;
            end else begin
              done_next  = 1'b0;
              op_next    = OP_COUNT;
              state_next = ST_SCAN;
            end
          end else begin
            case (req_type)
              REQ_INSERT: begin
                if (count < CNT_W'(DEPTH)) begin
                  mem_we         = 1'b1;
                  count_next     = count + 1'b1;
                  ok_next        = 1'b1;
                  occupancy_next = count + 1'b1;
                end
              end
              REQ_EXT_BACK: begin
                if (count != '0) begin
                  mem_raddr  = ring(front, ADDR_W'(count - 1'b1));
                  count_next = count - 1'b1;
                  done_next  = 1'b0;
                  state_next = ST_WAIT;
                end
              end
              REQ_EXT_FRONT: begin
                if (count != '0) begin
                  mem_raddr  = front;
                  front_next = ring(front, ADDR_W'(1));
                  count_next = count - 1'b1;
                  done_next  = 1'b0;
                  state_next = ST_WAIT;
                end
              end
              REQ_MIN, REQ_MAX: begin
                if (count != '0) begin
                  op_next    = (req_type == REQ_MIN) ? OP_MIN : OP_MAX;
                  done_next  = 1'b0;
                  state_next = ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_WAIT: begin
        done_next        = 1'b1;
        ok_next          = 1'b1;
        data_out_next    = rdata;
        match_count_next = '0;
        occupancy_next   = count;
        state_next       = ST_IDLE;
      end

      ST_SCAN: begin
        // issue side: one read per cycle
        mem_raddr = ring(front, issue_idx[ADDR_W-1:0]);
        if (issue_idx < count) begin
          rd_pend_next   = 1'b1;
          issue_idx_next = issue_idx + 1'b1;
        end
        // fold side: entry read last cycle
        if (rd_pend) begin
          case (op)
            OP_MIN: begin
              if (first || (rdata < best)) begin
                best_fold = rdata;
              end
            end
            OP_MAX: begin
              if (first || (rdata > best)) begin
                best_fold = rdata;
              end
            end
            OP_COUNT: begin
              if (rdata == val_q) begin
                match_fold = match_acc + 1'b1;
              end
            end
            default: begin
            end
          endcase
          best_next      = best_fold;
          match_acc_next = match_fold;
          proc_idx_next  = proc_idx + 1'b1;
          if (proc_idx == count - 1'b1) begin
            done_next        = 1'b1;
            ok_next          = 1'b1;
            data_out_next    = (op == OP_COUNT) ? '0 : best_fold;
            match_count_next = (op == OP_COUNT) ? match_fold : '0;
            occupancy_next   = count;
            rd_pend_next     = 1'b0;
            state_next       = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `BDQ_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "entry count above depth")
  `BDQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted item dropped")
  `BDQ_ASSERT_NEXT(a_extract_done, state == ST_WAIT, done && ok, "extract result missing")
  `BDQ_ASSERT_SAME(a_read_in_scan, rd_pend, state == ST_SCAN, "read pending outside scan")
  `BDQ_ASSERT_SAME(a_issue_bound, state == ST_SCAN, issue_idx <= count, "scan index overrun")

endmodule
